### hw/rtl/pmf_pkg.sv
`default_nettype none

package pmf_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int REQ_W      = 2;
  localparam int SLOT_MAX_W = 8;
  localparam int IDX_W      = 7;

  localparam int DEF_SLOT_COUNT   = 8;
  localparam int DEF_PACKET_BYTES = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_TAKEN    = 3'd0,
    STAT_COMMIT   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_LONG     = 3'd3,
    STAT_DISABLED = 3'd4,
    STAT_EMPTY    = 3'd5,
    STAT_DATA     = 3'd6,
    STAT_DROPPED  = 3'd7
  } status_t;

  typedef struct packed {
    logic                  pkt_we;
    logic                  pkt_re;
    logic [SLOT_MAX_W-1:0] pkt_slot;
    logic [IDX_W-1:0]      pkt_idx;
    logic [BYTE_W-1:0]     pkt_wdata;
    logic                  len_we;
    logic                  len_re;
    logic [SLOT_MAX_W-1:0] len_slot;
    logic [LEN_W-1:0]      len_wdata;
  } store_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/pmf_store.sv
`default_nettype none

module pmf_store
  import pmf_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  wire logic              clk,
  input  wire store_cmd_t        cmd,
  output logic      [BYTE_W-1:0] pkt_rdata,
  output logic      [LEN_W-1:0]  len_rdata
);

  localparam int DEPTH = SLOT_COUNT * PACKET_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(SLOT_COUNT);

  logic [BYTE_W-1:0] pkt_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem [SLOT_COUNT];

  logic [AW-1:0]     pkt_addr;
  logic [SW-1:0]     len_addr;
  logic [BYTE_W-1:0] pkt_rdata_r;
  logic [LEN_W-1:0]  len_rdata_r;

  assign pkt_addr = AW'(cmd.pkt_slot[SW-1:0]) * AW'(PACKET_BYTES) + AW'(cmd.pkt_idx);
  assign len_addr = cmd.len_slot[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.pkt_we) begin
      pkt_mem[pkt_addr] <= cmd.pkt_wdata;
    end
    if (cmd.pkt_re) begin
      pkt_rdata_r <= pkt_mem[pkt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_we) begin
      len_mem[len_addr] <= cmd.len_wdata;
    end
    if (cmd.len_re) begin
      len_rdata_r <= len_mem[len_addr];
    end
  end

  assign pkt_rdata = pkt_rdata_r;
  assign len_rdata = len_rdata_r;

endmodule

`default_nettype wire

### hw/rtl/packet_mailbox_fifo.sv
// Packet mailbox between two processors, kept as a ring of packet slots.
// Requests enter on the in_ stream: in_tuser selects push, pop or clear.
// A push carries one byte in in_tdata[7:0] and in_tlast on the final byte;
// a pop carries the reader limit in in_tdata[14:8].
// Every request except the unused code gives one or more results on the
// out_ stream: status in out_tuser, byte and length in out_tdata, and
// out_tlast on the final result of that request.
// Pushes and clears are handled in the idle state, so bytes stream in at one
// per cycle while the receiver takes the results; the result appears in the
// cycle after the request is accepted. A pop first reads the slot length from
// the length memory, then starts the packet memory reads; each byte passes
// through the packet memory read register to the output register, and bytes
// stream out at one per cycle while the receiver takes them.
// No new request is taken while a pop is streaming.
// When the receiver stalls, the output register holds its result and the
// packet read waits, so no byte is lost or repeated. The user must write the
// link enable register on the cfg_ stream while idle; the block does not
// enforce it. Reset empties the ring and clears the link enable; stored bytes
// and lengths keep their old contents, and no clearing pass is needed.
`default_nettype none

module packet_mailbox_fifo
  import pmf_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // data_byte [7:0], max_len [14:8], zero [15]
  input  wire logic [1:0]  in_tuser,  // req_type [1:0]
  input  wire logic        in_tlast,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata, // out_byte [7:0], out_len [14:8], zero [15]
  output logic      [2:0]  out_tuser, // status [2:0]
  output logic             out_tlast,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  localparam int SW = $clog2(SLOT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_POP_LEN  = 3'b010,
    ST_POP_DATA = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [SW-1:0]     pop_slot_r, pop_slot_nxt;
  logic [SW-1:0]     head_inc, tail_inc;
  logic [LEN_W-1:0]  bip_r, bip_nxt;
  logic [LEN_W-1:0]  push_len;
  logic [LEN_W-1:0]  maxl_r, maxl_nxt;
  logic [LEN_W-1:0]  pop_len_r, pop_len_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic              data_v_r, data_v_nxt;
  logic              link_en_r;

  logic              out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              out_load;
  status_t           ld_status;
  logic [BYTE_W-1:0] ld_byte;
  logic [LEN_W-1:0]  ld_len;
  logic              ld_last;

  logic              out_free;
  logic              in_fire;
  logic              move;
  logic              issue;
  logic              emit_last;
  req_t              in_req;
  logic [BYTE_W-1:0] in_byte;
  logic [LEN_W-1:0]  in_max;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] pkt_rdata;
  logic [LEN_W-1:0]  len_rdata;
  store_cmd_t        cmd;

  assign in_req  = req_t'(in_tuser);
  assign in_byte = in_tdata[7:0];
  assign in_max  = in_tdata[14:8];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign head_inc = (head_r == SW'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == SW'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
  assign push_len = (bip_r >= LEN_W'(PACKET_BYTES + 1)) ? LEN_W'(PACKET_BYTES + 1)
                                                        : bip_r + 1'b1;
  assign len_q    = (len_rdata > LEN_W'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES) : len_rdata;

  assign move      = (state_r == ST_POP_DATA) && data_v_r && out_free;
  assign issue     = (state_r == ST_POP_DATA) && (rd_idx_r < pop_len_r) &&
                     (!data_v_r || move);
  assign emit_last = (emit_cnt_r == pop_len_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    pop_slot_nxt = pop_slot_r;
    bip_nxt      = bip_r;
    maxl_nxt     = maxl_r;
    pop_len_nxt  = pop_len_r;
    rd_idx_nxt   = rd_idx_r;
    emit_cnt_nxt = emit_cnt_r;
    data_v_nxt   = data_v_r;
    cmd          = '0;
    out_load     = 1'b0;
    ld_status    = STAT_TAKEN;
    ld_byte      = '0;
    ld_len       = '0;
    ld_last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req)
            REQ_PUSH: begin
              out_load = 1'b1;
              if (!link_en_r) begin
                bip_nxt   = '0;
                ld_status = STAT_DISABLED;
              end else begin
                cmd.pkt_we    = (bip_r < LEN_W'(PACKET_BYTES));
                cmd.pkt_slot  = SLOT_MAX_W'(tail_r);
                cmd.pkt_idx   = bip_r;
                cmd.pkt_wdata = in_byte;
                if (!in_tlast) begin
                  bip_nxt   = push_len;
                  ld_status = STAT_TAKEN;
                end else begin
                  bip_nxt = '0;
                  if (push_len > LEN_W'(PACKET_BYTES)) begin
                    ld_status = STAT_LONG;
                  end else if (tail_inc == head_r) begin
                    ld_status = STAT_FULL;
                  end else begin
                    cmd.len_we    = 1'b1;
                    cmd.len_slot  = SLOT_MAX_W'(tail_r);
                    cmd.len_wdata = push_len;
                    tail_nxt      = tail_inc;
                    ld_status     = STAT_COMMIT;
                    ld_len        = push_len;
                  end
                end
              end
            end
            REQ_POP: begin
              if (!link_en_r || (head_r == tail_r)) begin
                out_load  = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                cmd.len_re   = 1'b1;
                cmd.len_slot = SLOT_MAX_W'(head_r);
                pop_slot_nxt = head_r;
                head_nxt     = head_inc;
                maxl_nxt     = in_max;
                state_nxt    = ST_POP_LEN;
              end
            end
            REQ_CLEAR: begin
              out_load = 1'b1;
              if (!link_en_r) begin
                ld_status = STAT_DISABLED;
              end else begin
                head_nxt  = '0;
                tail_nxt  = '0;
                bip_nxt   = '0;
                ld_status = STAT_TAKEN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_LEN: begin
        if (out_free) begin
          if ((len_q == '0) || (len_q > maxl_r)) begin
            out_load  = 1'b1;
            ld_status = STAT_DROPPED;
            ld_len    = len_q;
            state_nxt = ST_IDLE;
          end else begin
            pop_len_nxt  = len_q;
            rd_idx_nxt   = '0;
            emit_cnt_nxt = '0;
            data_v_nxt   = 1'b0;
            state_nxt    = ST_POP_DATA;
          end
        end
      end
      ST_POP_DATA: begin
        if (issue) begin
          cmd.pkt_re   = 1'b1;
          cmd.pkt_slot = SLOT_MAX_W'(pop_slot_r);
          cmd.pkt_idx  = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end
        data_v_nxt = issue || (data_v_r && !move);
        if (move) begin
          out_load     = 1'b1;
          ld_status    = STAT_DATA;
          ld_byte      = pkt_rdata;
          ld_len       = pop_len_r;
          ld_last      = emit_last;
          emit_cnt_nxt = emit_cnt_r + 1'b1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      bip_r       <= '0;
      data_v_r    <= 1'b0;
      link_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      bip_r    <= bip_nxt;
      data_v_r <= data_v_nxt;
      if (cfg_valid && cfg_ready) begin
        link_en_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_slot_r <= pop_slot_nxt;
    maxl_r     <= maxl_nxt;
    pop_len_r  <= pop_len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_byte_r   <= ld_byte;
      out_len_r    <= ld_len;
      out_last_r   <= ld_last;
    end
  end

  pmf_store #(
    .SLOT_COUNT   (SLOT_COUNT),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_store (
    .clk       (clk),
    .cmd       (cmd),
    .pkt_rdata (pkt_rdata),
    .len_rdata (len_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_byte_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    bip_r <= LEN_W'(PACKET_BYTES + 1))
    else $error("push byte count out of range");

  a_read_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_DATA) |-> (rd_idx_r == emit_cnt_r + LEN_W'(data_v_r)))
    else $error("packet read and emit counts disagree");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_DATA) |-> (emit_cnt_r < pop_len_r))
    else $error("pop emitted more bytes than the packet holds");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (move && emit_last) |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("pop did not finish on its last byte");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
  import pmf_pkg::*;

  localparam int SLOTS = DEF_SLOT_COUNT;
  localparam int PKT   = DEF_PACKET_BYTES;

  typedef struct {
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } mbox_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = REQ_NONE;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // Mailbox state as seen by the testbench.
  logic [BYTE_W-1:0] pkt_mem [SLOTS][PKT];
  int                len_mem [SLOTS];
  int                head_idx = 0;
  int                tail_idx = 0;
  int                fill_count = 0;
  bit                link_en = 1'b0;

  mbox_result_t exp_results[$];

  int tx_idle_pct = 34;
  int rx_idle_pct = 52;
  int rx_hold = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int status_hits [8];

  packet_mailbox_fifo i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int next_slot(int s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  function automatic void expect_result(status_t st, logic [BYTE_W-1:0] data, int len,
                                        logic last);
    mbox_result_t r;
    r.status = st;
    r.data   = data;
    r.len    = len[LEN_W-1:0];
    r.last   = last;
    exp_results.push_back(r);
  endfunction

  function automatic void mailbox_predict(req_t req, logic [BYTE_W-1:0] data, logic last,
                                          logic [LEN_W-1:0] limit);
    int plen;
    int slot;
    case (req)
      REQ_PUSH: begin
        if (!link_en) begin
          fill_count = 0;
          expect_result(STAT_DISABLED, '0, 0, 1'b1);
        end else begin
          if (fill_count < PKT) pkt_mem[tail_idx][fill_count] = data;
          plen = (fill_count + 1 > PKT + 1) ? PKT + 1 : fill_count + 1;
          if (!last) begin
            fill_count = plen;
            expect_result(STAT_TAKEN, '0, 0, 1'b1);
          end else begin
            fill_count = 0;
            if (plen > PKT) begin
              expect_result(STAT_LONG, '0, 0, 1'b1);
            end else if (next_slot(tail_idx) == head_idx) begin
              expect_result(STAT_FULL, '0, 0, 1'b1);
            end else begin
              len_mem[tail_idx] = plen;
              tail_idx = next_slot(tail_idx);
              expect_result(STAT_COMMIT, '0, plen, 1'b1);
            end
          end
        end
      end
      REQ_POP: begin
        if (!link_en || head_idx == tail_idx) begin
          expect_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          slot = head_idx;
          plen = (len_mem[slot] > PKT) ? PKT : len_mem[slot];
          head_idx = next_slot(head_idx);
          if (plen == 0 || plen > limit) begin
            expect_result(STAT_DROPPED, '0, plen, 1'b1);
          end else begin
            for (int i = 0; i < plen; i++)
              expect_result(STAT_DATA, pkt_mem[slot][i], plen, i == plen - 1);
          end
        end
      end
      REQ_CLEAR: begin
        if (!link_en) begin
          expect_result(STAT_DISABLED, '0, 0, 1'b1);
        end else begin
          head_idx = 0;
          tail_idx = 0;
          fill_count = 0;
          expect_result(STAT_TAKEN, '0, 0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    mbox_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      status_hits[out_tuser]++;
      if (exp_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: status %0d data %02h len %0d last %0b",
                   out_tuser, out_tdata[7:0], out_tdata[14:8], out_tlast);
      end else begin
        want = exp_results.pop_front();
        if (out_tuser !== want.status || out_tdata[7:0] !== want.data ||
            out_tdata[14:8] !== want.len || out_tdata[15] !== 1'b0 ||
            out_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"Mismatch: expected status %0d data %02h len %0d last %0b, ",
                      "got status %0d data %02h len %0d last %0b"},
                     want.status, want.data, want.len, want.last,
                     out_tuser, out_tdata[7:0], out_tdata[14:8], out_tlast);
        end
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_request(req_t req, logic [BYTE_W-1:0] data, logic last,
                              logic [LEN_W-1:0] limit);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {1'b0, limit, data};
    in_tlast  = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    mailbox_predict(req, data, last, limit);
    if (req != REQ_NONE) requests_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic push_packet(int len);
    for (int i = 0; i < len; i++)
      send_request(REQ_PUSH, BYTE_W'($urandom_range(255)), i == len - 1,
                   LEN_W'($urandom_range(64)));
  endtask

  task automatic wait_drained();
    while (exp_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_link(bit en);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = en;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    link_en = en;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_disabled_link();
    send_request(REQ_PUSH, 8'hFF, 1'b1, 7'd64);
    send_request(REQ_PUSH, 8'h00, 1'b0, 7'd0);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd64);
    send_request(REQ_CLEAR, 8'hFF, 1'b1, 7'd64);
    send_request(REQ_NONE, 8'hFF, 1'b1, 7'd64);
  endtask

  task automatic test_push_pop();
    set_link(1'b1);
    send_request(REQ_POP, 8'hFF, 1'b1, 7'd64);
    send_request(REQ_PUSH, 8'h00, 1'b1, 7'd0);
    send_request(REQ_PUSH, 8'hFF, 1'b0, 7'd64);
    send_request(REQ_PUSH, 8'hA5, 1'b1, 7'd0);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd1);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd1);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd0);
    send_request(REQ_PUSH, 8'h5A, 1'b1, 7'd64);
    send_request(REQ_POP, 8'hFF, 1'b1, 7'd0);
  endtask

  // A packet in progress is abandoned by a disabled push and by a clear.
  task automatic test_abandoned_packet();
    send_request(REQ_PUSH, 8'h3C, 1'b0, 7'd0);
    set_link(1'b0);
    send_request(REQ_PUSH, 8'hC3, 1'b1, 7'd0);
    set_link(1'b1);
    send_request(REQ_PUSH, 8'h81, 1'b1, 7'd0);
    send_request(REQ_PUSH, 8'h7E, 1'b0, 7'd0);
    send_request(REQ_CLEAR, 8'h00, 1'b0, 7'd0);
    send_request(REQ_PUSH, 8'h18, 1'b1, 7'd0);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd64);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd64);
  endtask

  // Leaves the ring full for the next test.
  task automatic test_full_ring();
    send_request(REQ_CLEAR, 8'h00, 1'b0, 7'd0);
    repeat (SLOTS - 1) push_packet(1);
    push_packet(2);
  endtask

  task automatic test_long_packets();
    push_packet(PKT + 1);
    send_request(REQ_CLEAR, 8'h00, 1'b0, 7'd0);
    push_packet(PKT);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd64);
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct = 0;
    rx_hold = 200;
    repeat (4) push_packet(6);
    repeat (4) send_request(REQ_POP, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                            7'd64);
    wait_drained();
    push_packet(3);
    send_request(REQ_POP, 8'h00, 1'b0, 7'd64);
  endtask

  task automatic run_random_phase(int n);
    int stop_at;
    int pick;
    stop_at = requests_sent + n;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_packet(($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(24, 9));
      end else if (pick < 85) begin
        send_request(REQ_POP, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     LEN_W'(($urandom_range(99) < 80) ? $urandom_range(64)
                                                      : $urandom_range(8)));
      end else if (pick < 90) begin
        send_request(REQ_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     LEN_W'($urandom_range(64)));
      end else if (pick < 95) begin
        send_request(REQ_PUSH, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     LEN_W'($urandom_range(64)));
      end else begin
        send_request(REQ_NONE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     LEN_W'($urandom_range(64)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_disabled_link();
    test_push_pop();
    test_abandoned_packet();
    test_full_ring();
    test_long_packets();
    test_backpressure();

    tx_idle_pct = 34;
    rx_idle_pct = 52;
    run_random_phase(20);
    set_link(1'b0);
    run_random_phase(6);
    set_link(1'b1);
    tx_idle_pct = 52;
    rx_idle_pct = 34;
    run_random_phase(20);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(20);
    wait_drained();

    errors = errors + exp_results.size();
    $display("Sent %0d requests and checked %0d results, with the link enabled and disabled.",
             requests_sent, results_seen);
    $display({"Status counts: taken %0d commit %0d full %0d long %0d ",
              "disabled %0d empty %0d data %0d dropped %0d"},
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout while requests or results were still outstanding.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
